### hw/rtl/e2q_pkg.sv
// shared types, constants and the quarter-wave sine table for the euler to quaternion block
package e2q_pkg;

    // field widths
    localparam int ANG_W         = 9;
    localparam int Q_W           = 16;
    localparam int FRAC_BITS_DEF = 15;

    // sine table: one entry per half degree over a quarter wave, Q30
    localparam int TAB_LEN  = 181;
    localparam int TAB_W    = 31;
    localparam int TAB_FRAC = 30;
    localparam int IDX_W    = 8;

    // signed factor and product widths
    localparam int FAC_W = 32;
    localparam int P_W   = 62;
    localparam int S_W   = 63;

    // half-angle positions on the circle, in half-degree units
    localparam int A_W = 10;
    localparam logic [A_W-1:0] QTR_TURN  = 10'd180;
    localparam logic [A_W-1:0] HALF_TURN = 10'd360;
    localparam logic [A_W-1:0] TQTR_TURN = 10'd540;
    localparam logic [A_W-1:0] FULL_TURN = 10'd720;

    // folded table address with the sign of the quadrant
    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] idx;
    } fold_t;

    typedef logic [TAB_W-1:0] tab_t [TAB_LEN];

    // table generation constants, evaluated at elaboration only
    localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ROUND_Q32    = 64'h0000_0000_8000_0000;
    localparam logic [63:0] STEP_Q62     = PI_Q62 / 64'd360;
    localparam int          TAYLOR_TERMS = 13;

    // (a * b) >> 62, kept to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // unsigned quotient by shift and subtract, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        int          b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // taylor series sine per half-degree step, rounded to Q30
    function automatic tab_t build_sin_tab();
        tab_t        tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] r;
        int          k;
        int          j;
        for (k = 0; k < TAB_LEN; k++)
        begin
            x  = STEP_Q62 * 64'(k);
            x2 = mul_q62(x, x);
            t  = ONE_Q62;
            for (j = TAYLOR_TERMS; j >= 1; j--)
            begin
                d = 64'(2 * j) * 64'(2 * j + 1);
                t = ONE_Q62 - udiv64(mul_q62(x2, t), d);
            end
            s      = mul_q62(x, t);
            r      = s + ROUND_Q32;
            tab[k] = r[62:32];
        end
        return tab;
    endfunction

    localparam tab_t SIN_TAB = build_sin_tab();

endpackage

### hw/rtl/e2q_fold.sv
// folds one angle into quarter-wave table addresses for its half-angle sine and cosine
module e2q_fold (
    input  logic signed [e2q_pkg::ANG_W-1:0] angle,
    output e2q_pkg::fold_t                   sin_f,
    output e2q_pkg::fold_t                   cos_f
);
    import e2q_pkg::*;

    logic signed [A_W:0]  sin_s;
    logic signed [A_W:0]  cos_s;
    logic        [A_W-1:0] sin_a;
    logic        [A_W-1:0] cos_a;

    // map a position on the circle onto the quarter wave with a sign
    function automatic fold_t fold_pos(input logic [A_W-1:0] a);
        fold_t f;
        f.neg = 1'b0;
        f.idx = '0;
        if (a <= QTR_TURN)
        begin
            f.idx = a[IDX_W-1:0];
        end
        else if (a <= HALF_TURN)
        begin
            f.idx = IDX_W'(HALF_TURN - a);
        end
        else if (a <= TQTR_TURN)
        begin
            f.neg = 1'b1;
            f.idx = IDX_W'(a - HALF_TURN);
        end
        else
        begin
            f.neg = 1'b1;
            f.idx = IDX_W'(FULL_TURN - a);
        end
        return f;
    endfunction

    // half-angle in half-degree units is the angle in degrees; wrap into one turn
    always_comb
    begin
        sin_s = (A_W+1)'(angle);
        cos_s = (A_W+1)'(angle) + (A_W+1)'(signed'({1'b0, QTR_TURN}));
        sin_a = (sin_s < 0) ? A_W'(sin_s + (A_W+1)'(signed'({1'b0, FULL_TURN}))) : A_W'(sin_s);
        cos_a = (cos_s < 0) ? A_W'(cos_s + (A_W+1)'(signed'({1'b0, FULL_TURN}))) : A_W'(cos_s);
        sin_f = fold_pos(sin_a);
        cos_f = fold_pos(cos_a);
    end

endmodule

### hw/rtl/euler_to_quaternion.sv
// top level: pitch, yaw and roll in degrees to a Q1.15 rotation quaternion, seven-stage pipeline
//
// Converts three whole-degree Euler angles (any 9-bit two's complement value, periodic) to the
// quaternion x, y, z, w in signed Q1.FRAC_BITS, rounded to nearest and saturated just below
// +1.0 and at -1.0. No state is carried from one beat to the next: while the output is not
// stalled one beat may enter every cycle, and results leave in order. The stages are angle
// folding, quarter-wave sine table read, first product, rounding to Q30, second product, sum,
// and final rounding with saturation; each multiply stage holds one 32x32 multiplier per
// product and sets the clock path. Every stage has its own valid bit and loads when it is
// empty or when the stage after it moves, so a stall on the output side only backs up as far
// as the pipeline is full and bubbles are squeezed out.
module euler_to_quaternion #(
    parameter int FRAC_BITS = e2q_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pitch_deg[8:0], yaw_deg[17:9], roll_deg[26:18], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
);
    import e2q_pkg::*;

    // pipeline stages
    localparam int ST_FOLD = 0;
    localparam int ST_TAB  = 1;
    localparam int ST_MUL1 = 2;
    localparam int ST_RND  = 3;
    localparam int ST_MUL2 = 4;
    localparam int ST_SUM  = 5;
    localparam int ST_OUT  = 6;
    localparam int NUM_ST  = 7;

    // factor slots
    localparam int F_SP  = 0;
    localparam int F_CP  = 1;
    localparam int F_SY  = 2;
    localparam int F_CY  = 3;
    localparam int F_SR  = 4;
    localparam int F_CR  = 5;
    localparam int N_FAC = 6;

    // roll-pitch product slots
    localparam int R_SRCP = 0;
    localparam int R_CRSP = 1;
    localparam int R_CRCP = 2;
    localparam int R_SRSP = 3;
    localparam int N_RP   = 4;

    // quaternion slots and yaw terms
    localparam int QX    = 0;
    localparam int QY    = 1;
    localparam int QZ    = 2;
    localparam int QW    = 3;
    localparam int N_Q   = 4;
    localparam int N_TRM = 2 * N_Q;

    // final rounding and saturation
    localparam int SH  = 2 * TAB_FRAC - FRAC_BITS;
    localparam int R_W = S_W - SH;
    localparam logic signed [P_W-1:0] RQ_HALF  = P_W'(1) << (TAB_FRAC - 1);
    localparam logic signed [S_W-1:0] RND_HALF = S_W'(1) << (SH - 1);
    localparam logic signed [R_W-1:0] SAT_HI   = {{(R_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [R_W-1:0] SAT_LO   = {{(R_W - FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

    // flow control
    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST-1:0] vld_next;
    logic [NUM_ST-1:0] en;

    // stage data
    fold_t                    fold_in  [N_FAC];
    fold_t                    fold_reg [N_FAC];
    logic signed [FAC_W-1:0]  fac_in   [N_FAC];
    logic signed [FAC_W-1:0]  fac_reg  [N_FAC];
    logic signed [2*FAC_W-1:0] m1_full [N_RP];
    logic signed [P_W-1:0]    rp_reg   [N_RP];
    logic signed [FAC_W-1:0]  sy_m1_reg;
    logic signed [FAC_W-1:0]  cy_m1_reg;
    logic signed [P_W-1:0]    rq_full  [N_RP];
    logic signed [FAC_W-1:0]  rq_reg   [N_RP];
    logic signed [FAC_W-1:0]  sy_rd_reg;
    logic signed [FAC_W-1:0]  cy_rd_reg;
    logic signed [2*FAC_W-1:0] m2_full [N_TRM];
    logic signed [P_W-1:0]    t_reg    [N_TRM];
    logic signed [S_W-1:0]    sum_reg  [N_Q];
    logic signed [S_W-1:0]    rnd_full [N_Q];
    logic signed [R_W-1:0]    rnd      [N_Q];
    logic signed [R_W-1:0]    sat      [N_Q];
    logic        [Q_W-1:0]    q_reg    [N_Q];

    // per-stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NUM_ST-1] = !vld_reg[NUM_ST-1] || m_axis_tready;
        for (int i = NUM_ST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? s_axis_tvalid : vld_reg[0];
        for (int i = 1; i < NUM_ST; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = en[ST_FOLD];
    assign m_axis_tvalid = vld_reg[ST_OUT];
    assign m_axis_tdata  = {q_reg[QW], q_reg[QZ], q_reg[QY], q_reg[QX]};

    // stage 1: fold each angle onto the quarter wave
    e2q_fold u_fold_p (
        .angle (signed'(s_axis_tdata[ANG_W-1:0])),
        .sin_f (fold_in[F_SP]),
        .cos_f (fold_in[F_CP])
    );

    e2q_fold u_fold_y (
        .angle (signed'(s_axis_tdata[2*ANG_W-1:ANG_W])),
        .sin_f (fold_in[F_SY]),
        .cos_f (fold_in[F_CY])
    );

    e2q_fold u_fold_r (
        .angle (signed'(s_axis_tdata[3*ANG_W-1:2*ANG_W])),
        .sin_f (fold_in[F_SR]),
        .cos_f (fold_in[F_CR])
    );

    always_ff @(posedge clk)
    begin
        if (en[ST_FOLD])
        begin
            fold_reg <= fold_in;
        end
    end

    // stage 2: table read with quadrant sign
    always_comb
    begin
        for (int i = 0; i < N_FAC; i++)
        begin
            fac_in[i] = fold_reg[i].neg ? -signed'(FAC_W'(SIN_TAB[fold_reg[i].idx]))
                                        :  signed'(FAC_W'(SIN_TAB[fold_reg[i].idx]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_TAB])
        begin
            fac_reg <= fac_in;
        end
    end

    // stage 3: roll-pitch products, yaw factors ride along
    always_comb
    begin
        m1_full[R_SRCP] = fac_reg[F_SR] * fac_reg[F_CP];
        m1_full[R_CRSP] = fac_reg[F_CR] * fac_reg[F_SP];
        m1_full[R_CRCP] = fac_reg[F_CR] * fac_reg[F_CP];
        m1_full[R_SRSP] = fac_reg[F_SR] * fac_reg[F_SP];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL1])
        begin
            for (int i = 0; i < N_RP; i++)
            begin
                rp_reg[i] <= m1_full[i][P_W-1:0];
            end
            sy_m1_reg <= fac_reg[F_SY];
            cy_m1_reg <= fac_reg[F_CY];
        end
    end

    // stage 4: round Q60 to Q30, half up
    always_comb
    begin
        for (int i = 0; i < N_RP; i++)
        begin
            rq_full[i] = (rp_reg[i] + RQ_HALF) >>> TAB_FRAC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_RND])
        begin
            for (int i = 0; i < N_RP; i++)
            begin
                rq_reg[i] <= rq_full[i][FAC_W-1:0];
            end
            sy_rd_reg <= sy_m1_reg;
            cy_rd_reg <= cy_m1_reg;
        end
    end

    // stage 5: multiply by the yaw factors, two terms per component
    always_comb
    begin
        m2_full[2*QX]   = rq_reg[R_SRCP] * cy_rd_reg;
        m2_full[2*QX+1] = rq_reg[R_CRSP] * sy_rd_reg;
        m2_full[2*QY]   = rq_reg[R_CRSP] * cy_rd_reg;
        m2_full[2*QY+1] = rq_reg[R_SRCP] * sy_rd_reg;
        m2_full[2*QZ]   = rq_reg[R_CRCP] * sy_rd_reg;
        m2_full[2*QZ+1] = rq_reg[R_SRSP] * cy_rd_reg;
        m2_full[2*QW]   = rq_reg[R_CRCP] * cy_rd_reg;
        m2_full[2*QW+1] = rq_reg[R_SRSP] * sy_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL2])
        begin
            for (int i = 0; i < N_TRM; i++)
            begin
                t_reg[i] <= m2_full[i][P_W-1:0];
            end
        end
    end

    // stage 6: exact sums and differences
    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sum_reg[QX] <= S_W'(t_reg[2*QX]) - S_W'(t_reg[2*QX+1]);
            sum_reg[QY] <= S_W'(t_reg[2*QY]) + S_W'(t_reg[2*QY+1]);
            sum_reg[QZ] <= S_W'(t_reg[2*QZ]) - S_W'(t_reg[2*QZ+1]);
            sum_reg[QW] <= S_W'(t_reg[2*QW]) + S_W'(t_reg[2*QW+1]);
        end
    end

    // stage 7: round to the output fraction and saturate
    always_comb
    begin
        for (int i = 0; i < N_Q; i++)
        begin
            rnd_full[i] = (sum_reg[i] + RND_HALF) >>> SH;
            rnd[i]      = rnd_full[i][R_W-1:0];
            if (rnd[i] > SAT_HI)
            begin
                sat[i] = SAT_HI;
            end
            else if (rnd[i] < SAT_LO)
            begin
                sat[i] = SAT_LO;
            end
            else
            begin
                sat[i] = rnd[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            for (int i = 0; i < N_Q; i++)
            begin
                q_reg[i] <= Q_W'(sat[i]);
            end
        end
    end

`ifndef SYNTHESIS
    // a pipeline with any empty stage must take a new beat
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> s_axis_tready)
        else $error("input stalled while the pipeline has room");

    // an accepted beat always lands in the fold stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[ST_FOLD])
        else $error("accepted beat lost at pipeline entry");

    // folded table addresses stay within the quarter wave
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_FOLD] |-> (fold_reg[F_SP].idx <= IDX_W'(QTR_TURN))
                          && (fold_reg[F_CP].idx <= IDX_W'(QTR_TURN))
                          && (fold_reg[F_SY].idx <= IDX_W'(QTR_TURN))
                          && (fold_reg[F_CY].idx <= IDX_W'(QTR_TURN))
                          && (fold_reg[F_SR].idx <= IDX_W'(QTR_TURN))
                          && (fold_reg[F_CR].idx <= IDX_W'(QTR_TURN)))
        else $error("folded table address beyond the quarter wave");
`endif

endmodule
